[hdl/gssc_pkg.sv]
// Shared types, position codes and helpers for the gear selector stepper control.
`timescale 1ns / 1ps

package gssc_pkg;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_REQUEST = 2'd1,
    FUNC_ENABLE  = 2'd2,
    FUNC_DISABLE = 2'd3
  } func_e;

  // Selector position character codes.
  localparam logic [7:0] CODE_NONE = 8'h00;
  localparam logic [7:0] CODE_P    = 8'h50;
  localparam logic [7:0] CODE_R    = 8'h52;
  localparam logic [7:0] CODE_N    = 8'h4E;
  localparam logic [7:0] CODE_D    = 8'h44;

  localparam logic [15:0] HOLD_TICKS_RESET = 16'd150;
  localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

  // Configuration register indexes, word addressed.
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam logic        CFG_IDX_HOLD = 1'b0;

  // One result item.
  typedef struct packed {
    logic       control_on;
    logic       motor_on;
    logic       turn_clockwise;
    logic       step_now;
    logic       override_flag;
    logic       fault_code_set;
    logic       fault_report;
    logic [7:0] pending_request;
  } result_t;

  // Gear order P=1, R=2, N=3, D=4; anything else maps to 0.
  function automatic logic [2:0] gear_index(input logic [7:0] code);
    logic [2:0] idx;
    case (code)
      CODE_P:  idx = 3'd1;
      CODE_R:  idx = 3'd2;
      CODE_N:  idx = 3'd3;
      CODE_D:  idx = 3'd4;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

[hdl/gear_selector_stepper_control.sv]
// Top level of the gear selector stepper control: state update, result register and skid stage.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_stall_o    | func, request_code, current_code,
//           |           |                            | brake_pressed, vehicle_speed
//   out     | output    | out_valid_o / out_stall_i  | control_on .. pending_request
//   cfg     | APB       | psel/penable/pwrite/pready | override_hold_ticks at byte address 0
//
// The state update is a single pass of logic from the input ports into the state and result
// registers, so one item is accepted every cycle while in_stall_o is low.
// A result waits in the result register, or in the skid register while the output stalls.
// A skid register holds one more result while the output stalls; the input stalls only
// when both the result register and the skid register are full.
// Reset clears all control state and sets override_hold_ticks to 150.
`timescale 1ns / 1ps

module gear_selector_stepper_control
  import gssc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [7:0]            request_code_i,
  input  logic [7:0]            current_code_i,
  input  logic                  brake_pressed_i,
  input  logic [15:0]           vehicle_speed_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  control_on_o,
  output logic                  motor_on_o,
  output logic                  turn_clockwise_o,
  output logic                  step_now_o,
  output logic                  override_flag_o,
  output logic                  fault_code_set_o,
  output logic                  fault_report_o,
  output logic [7:0]            pending_request_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] hold_ticks_q;

  logic        enabled_q,  enabled_d;
  logic [7:0]  req_pos_q,  req_pos_d;
  logic [7:0]  reach_pos_q, reach_pos_d;
  logic        override_q, override_d;
  logic        fault_q,    fault_d;
  logic        timing_q,   timing_d;
  logic [15:0] ticks_q,    ticks_d;
  logic        driver_q,   driver_d;
  logic        dir_q,      dir_d;

  result_t     res_d;
  result_t     main_q, skid_q;
  logic        main_valid_q, skid_valid_q;

  logic        in_xfer;
  logic        out_xfer;
  logic        cfg_write;

  logic        still;
  logic        fault;
  logic        step;
  logic [15:0] ticks_inc;
  logic [2:0]  req_idx;
  logic [2:0]  cur_idx;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = main_valid_q && !out_stall_i;
  assign cfg_write = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_HOLD) ? {16'd0, hold_ticks_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_TICKS_RESET;
    end else if (cfg_write && paddr[2] == CFG_IDX_HOLD) begin
      hold_ticks_q <= pwdata[15:0];
    end
  end

  assign still     = (vehicle_speed_i == 16'd0);
  assign req_idx   = gear_index(req_pos_q);
  assign cur_idx   = gear_index(current_code_i);
  assign ticks_inc = (ticks_q != TICKS_MAX) ? ticks_q + 16'd1 : ticks_q;

  always_comb begin
    enabled_d   = enabled_q;
    req_pos_d   = req_pos_q;
    reach_pos_d = reach_pos_q;
    override_d  = override_q;
    fault_d     = fault_q;
    timing_d    = timing_q;
    ticks_d     = ticks_q;
    driver_d    = driver_q;
    dir_d       = dir_q;
    fault       = 1'b0;
    step        = 1'b0;

    case (func_e'(func_i))
      FUNC_REQUEST: begin
        if (enabled_q && brake_pressed_i && still) begin
          req_pos_d = request_code_i;
        end
      end
      FUNC_ENABLE: begin
        if (!enabled_q && !override_q) begin
          enabled_d = 1'b1;
        end
      end
      FUNC_DISABLE: begin
        if (enabled_q) begin
          enabled_d = 1'b0;
          driver_d  = 1'b0;
          dir_d     = 1'b0;
        end
      end
      FUNC_TICK: begin
        // The override check runs before the move step and may turn control off.
        if (enabled_q || fault_q) begin
          if (reach_pos_q != CODE_NONE && req_pos_q == CODE_NONE) begin
            if (reach_pos_q == current_code_i) begin
              timing_d = 1'b0;
            end else if (!timing_q) begin
              timing_d = 1'b1;
              ticks_d  = 16'd0;
            end else begin
              ticks_d = ticks_inc;
              fault   = (ticks_inc >= hold_ticks_q);
            end
          end
          if (fault) begin
            if (enabled_q) begin
              enabled_d = 1'b0;
              driver_d  = 1'b0;
              dir_d     = 1'b0;
            end
            fault_d    = 1'b1;
            override_d = 1'b1;
          end else begin
            fault_d    = 1'b0;
            override_d = 1'b0;
          end
        end
        if (enabled_d) begin
          if (req_pos_q != CODE_NONE) begin
            if (brake_pressed_i && still) begin
              if (current_code_i != req_pos_q) begin
                driver_d = 1'b1;
                // Unknown codes keep the driver on but give no direction to step in.
                if (req_idx != 3'd0 && cur_idx != 3'd0) begin
                  dir_d = (req_idx > cur_idx);
                  step  = 1'b1;
                end
              end else begin
                driver_d    = 1'b0;
                reach_pos_d = req_pos_q;
                req_pos_d   = CODE_NONE;
              end
            end else begin
              driver_d  = 1'b0;
              req_pos_d = CODE_NONE;
            end
          end else begin
            driver_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    res_d.control_on      = enabled_d;
    res_d.motor_on        = driver_d;
    res_d.turn_clockwise  = dir_d;
    res_d.step_now        = step;
    res_d.override_flag   = override_d;
    res_d.fault_code_set  = fault_d;
    res_d.fault_report    = fault;
    res_d.pending_request = req_pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      req_pos_q   <= CODE_NONE;
      reach_pos_q <= CODE_NONE;
      override_q  <= 1'b0;
      fault_q     <= 1'b0;
      timing_q    <= 1'b0;
      ticks_q     <= 16'd0;
      driver_q    <= 1'b0;
      dir_q       <= 1'b0;
    end else if (in_xfer) begin
      enabled_q   <= enabled_d;
      req_pos_q   <= req_pos_d;
      reach_pos_q <= reach_pos_d;
      override_q  <= override_d;
      fault_q     <= fault_d;
      timing_q    <= timing_d;
      ticks_q     <= ticks_d;
      driver_q    <= driver_d;
      dir_q       <= dir_d;
    end
  end

  // The skid register always holds the newer of the two waiting results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_xfer || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer || !main_valid_q) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (in_xfer) begin
        main_q <= res_d;
      end
    end else if (in_xfer) begin
      skid_q <= res_d;
    end
  end

  assign in_stall_o        = skid_valid_q;
  assign out_valid_o       = main_valid_q;
  assign control_on_o      = main_q.control_on;
  assign motor_on_o        = main_q.motor_on;
  assign turn_clockwise_o  = main_q.turn_clockwise;
  assign step_now_o        = main_q.step_now;
  assign override_flag_o   = main_q.override_flag;
  assign fault_code_set_o  = main_q.fault_code_set;
  assign fault_report_o    = main_q.fault_report;
  assign pending_request_o = main_q.pending_request;

endmodule

[hdl/gssc_checker.sv]
// Port-level checker for the gear selector stepper control and its bind statement.
`timescale 1ns / 1ps

module gssc_checker
  import gssc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  control_on_o,
  input logic                  motor_on_o,
  input logic                  step_now_o,
  input logic                  override_flag_o,
  input logic                  fault_code_set_o,
  input logic                  fault_report_o,
  input logic [7:0]            pending_request_o,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata
);

  // A stalled result transfer stays valid and keeps its pending request, control and step fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pending_request_o)
      && $stable(control_on_o) && $stable(step_now_o))
    else $error("output result changed while stalled");

  // A step pulse only happens with control and the driver on.
  a_step_driver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_now_o |-> motor_on_o && control_on_o)
    else $error("step issued with driver or control off");

  // A fault report leaves control off with override and fault code latched.
  a_fault_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_report_o |-> !control_on_o && override_flag_o && fault_code_set_o)
    else $error("fault report without latched fault state");

  // A register write is visible to a read in the next cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[2] == CFG_IDX_HOLD
      |=> !(paddr[2] == CFG_IDX_HOLD && !pwrite) || prdata[15:0] == $past(pwdata[15:0]))
    else $error("hold ticks register readback mismatch");

endmodule

bind gear_selector_stepper_control gssc_checker u_gssc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .control_on_o      (control_on_o),
  .motor_on_o        (motor_on_o),
  .step_now_o        (step_now_o),
  .override_flag_o   (override_flag_o),
  .fault_code_set_o  (fault_code_set_o),
  .fault_report_o    (fault_report_o),
  .pending_request_o (pending_request_o),
  .psel              (psel),
  .penable           (penable),
  .pwrite            (pwrite),
  .paddr             (paddr),
  .pwdata            (pwdata),
  .prdata            (prdata)
);
